@@ design/sfpx_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpx_pkg
// Shared widths and register indexes of the serial frame parser.
// ----------------------------------------------------------------------------
package sfpx_pkg;

  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 5;
  localparam int IDX_W    = 4;
  localparam int CNT_W    = 16;
  localparam int CFG_IW   = 2;
  localparam int BURST_CAP = 16;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [LEN_W-1:0]  len_t;

  localparam logic [CFG_IW-1:0] REG_START_BYTE   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_HIGHEST_TYPE = 2'd1;
  localparam logic [CFG_IW-1:0] REG_QUERY_TYPE   = 2'd2;
  localparam logic [CFG_IW-1:0] REG_LONGEST_LEN  = 2'd3;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

endpackage

@@ design/sfpx_payload_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpx_payload_ram
// Payload buffer: one write port and one registered read port.
// ----------------------------------------------------------------------------
module sfpx_payload_ram
  import sfpx_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  byte_t         wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output byte_t         rd_data
);

  byte_t mem [DEPTH];
  byte_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/serial_frame_parser_xor_check_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_parser_xor_check_core
// Start-byte framed parser with type and length header and XOR checksum.
// ----------------------------------------------------------------------------
// Input bytes are taken while the parser is collecting a frame. On the
// checksum byte the frame is played out as a burst of one transfer per
// payload byte; each result passes through the payload buffer read and then
// the load of the output register, and the next read waits for that load, so
// input is held off until the last buffer read is issued, and longer while
// the result side stalls. The last result may still wait in the output
// register while the next byte is accepted.
module serial_frame_parser_xor_check_core
  import sfpx_pkg::*;
#(
  parameter int MAX_PAYLOAD = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  byte_t             cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  byte_t             in_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output byte_t             out_frame_type,
  output len_t              out_frame_length,
  output logic [IDX_W-1:0]  out_byte_index,
  output byte_t             out_payload_byte,
  output logic              out_checksum_ok,
  output logic [CNT_W-1:0]  out_mismatch_total,
  output logic              out_last
);

  localparam int DEPTH = (MAX_PAYLOAD < BURST_CAP) ? MAX_PAYLOAD : BURST_CAP;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam len_t LEN_CAP = LEN_W'(DEPTH);

  byte_t            start_byte_r, hi_type_r, query_type_r;
  len_t             longest_r;
  logic             in_frame_r;
  byte_t            held_type_r;
  len_t             held_len_r;
  len_t             fill_r;
  byte_t            xor_r;
  logic [CNT_W-1:0] bad_cnt_r;
  logic             ok_r;
  logic             busy_r;
  len_t             rd_idx_r;
  logic             rd_pend_r;
  logic [IDX_W-1:0] pend_idx_r;
  logic             out_valid_r;

  logic             in_xfer;
  logic             rd_issue;
  logic             wr_en;
  byte_t            rd_data;
  len_t             len_lim;
  len_t             rd_idx_nxt;
  logic             chk_ok;

  assign in_ready = !busy_r;
  assign in_xfer  = in_valid && in_ready;
  assign len_lim  = (longest_r < LEN_CAP) ? longest_r : LEN_CAP;
  assign chk_ok   = (in_byte == xor_r);
  assign wr_en    = in_xfer && in_frame_r && (held_type_r != '0) &&
                    (held_len_r != '0) && (fill_r < held_len_r);
  assign rd_issue = busy_r && !rd_pend_r && (!out_valid_r || out_ready);
  assign rd_idx_nxt = rd_idx_r + LEN_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= BYTE_W'(43);
      hi_type_r    <= BYTE_W'(3);
      query_type_r <= BYTE_W'(255);
      longest_r    <= LEN_W'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_BYTE:   start_byte_r <= cfg_wdata;
        REG_HIGHEST_TYPE: hi_type_r    <= cfg_wdata;
        REG_QUERY_TYPE:   query_type_r <= cfg_wdata;
        REG_LONGEST_LEN:  longest_r    <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      held_type_r <= '0;
      held_len_r  <= '0;
      fill_r      <= '0;
      xor_r       <= '0;
      bad_cnt_r   <= '0;
      ok_r        <= 1'b0;
      busy_r      <= 1'b0;
      rd_idx_r    <= '0;
    end else begin
      if (in_xfer) begin
        if (!in_frame_r) begin
          if (in_byte == start_byte_r) begin
            in_frame_r  <= 1'b1;
            held_type_r <= '0;
            held_len_r  <= '0;
            fill_r      <= '0;
            xor_r       <= in_byte;
          end
        end else if (held_type_r == '0) begin
          if (in_byte > hi_type_r && in_byte != query_type_r) begin
            in_frame_r <= 1'b0;
          end else if (in_byte != '0) begin
            held_type_r <= in_byte;
            xor_r       <= xor_r ^ in_byte;
          end
        end else if (held_len_r == '0) begin
          if (in_byte > BYTE_W'(len_lim)) begin
            in_frame_r <= 1'b0;
          end else if (in_byte != '0) begin
            held_len_r <= in_byte[LEN_W-1:0];
            xor_r      <= xor_r ^ in_byte;
          end
        end else if (fill_r < held_len_r) begin
          fill_r <= fill_r + LEN_W'(1);
          xor_r  <= xor_r ^ in_byte;
        end else begin
          ok_r       <= chk_ok;
          in_frame_r <= 1'b0;
          busy_r     <= 1'b1;
          rd_idx_r   <= '0;
          if (!chk_ok && bad_cnt_r != CNT_MAX) begin
            bad_cnt_r <= bad_cnt_r + CNT_W'(1);
          end
        end
      end
      if (rd_issue) begin
        rd_idx_r <= rd_idx_nxt;
        if (rd_idx_nxt == held_len_r) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  sfpx_payload_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_r[AW-1:0]),
    .wr_data (in_byte),
    .rd_en   (rd_issue),
    .rd_addr (rd_idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r <= rd_issue;
      if (rd_pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      pend_idx_r <= rd_idx_r[IDX_W-1:0];
    end
    if (rd_pend_r) begin
      out_frame_type     <= held_type_r;
      out_frame_length   <= held_len_r;
      out_byte_index     <= pend_idx_r;
      out_payload_byte   <= rd_data;
      out_checksum_ok    <= ok_r;
      out_mismatch_total <= bad_cnt_r;
      out_last           <= ((LEN_W'(pend_idx_r) + LEN_W'(1)) == held_len_r);
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_pend_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> !out_valid_r)
    else $error("Buffer read returned while the output register was occupied.");

  a_pend_loads: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |=> out_valid_r)
    else $error("Buffer read data was not loaded into the output register.");

  a_busy_idle_frame: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_frame_r)
    else $error("Burst in progress while a frame is being collected.");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (in_frame_r && held_len_r != '0) |-> (fill_r <= held_len_r && held_len_r <= LEN_CAP))
    else $error("Payload fill count ran past the frame length.");

  a_bad_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && $past(rst_n) && bad_cnt_r != $past(bad_cnt_r)) |->
      (bad_cnt_r == $past(bad_cnt_r) + CNT_W'(1)))
    else $error("Mismatch count moved by other than one.");
`endif

endmodule
